// ===== src/iss_pkg.sv =====
// Shared types and codes for the indexed sequence store.
package iss_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 7;

  typedef struct packed {
    mode_t                  mode;
    logic [POSITION_W-1:0]  position;
    logic signed [VALUE_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] head_value;
    logic signed [VALUE_W-1:0] tail_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    status_t                   status;
  } rsp_word_t;

endpackage

// ===== src/iss_cell.sv =====
// One storage cell of the shifting chain.
module iss_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic                               clk,
  input  iss_pkg::cell_op_t                  op,
  input  logic [CW-1:0]                      pos,
  input  logic signed [iss_pkg::VALUE_W-1:0] value,
  input  logic signed [iss_pkg::VALUE_W-1:0] left,
  input  logic signed [iss_pkg::VALUE_W-1:0] right,
  output logic signed [iss_pkg::VALUE_W-1:0] stored
);
  import iss_pkg::*;

  localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

  logic signed [VALUE_W-1:0] stored_next;

  always_comb begin
    stored_next = stored;
    unique case (op)
      CELL_INSERT: begin
        if (MY_INDEX == pos) begin
          stored_next = value;
        end else if (MY_INDEX > pos) begin
          stored_next = left;
        end
      end
      CELL_REMOVE: begin
        if (MY_INDEX >= pos) begin
          stored_next = right;
        end
      end
      default: stored_next = stored;
    endcase
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

// ===== src/iss_chain.sv =====
// A row of cells in which each cell takes from its neighbors on a shift.
module iss_chain #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic                               clk,
  input  iss_pkg::cell_op_t                  op,
  input  logic [CW-1:0]                      pos,
  input  logic signed [iss_pkg::VALUE_W-1:0] value,
  output logic signed [iss_pkg::VALUE_W-1:0] first
);
  import iss_pkg::*;

  logic signed [VALUE_W-1:0] q [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_left
      assign left = q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = q[k+1];
    end

    iss_cell #(
      .CW    (CW),
      .INDEX (k)
    ) u_cell (
      .clk    (clk),
      .op     (op),
      .pos    (pos),
      .value  (value),
      .left   (left),
      .right  (right),
      .stored (q[k])
    );
  end

  assign first = q[0];

endmodule

// ===== src/indexed_sequence_store.sv =====
// Top level of the indexed sequence store.
// Each accepted word appends, inserts before a position, removes at a position or does
// nothing, and its result word appears in the next cycle; a new word is taken in the same
// cycle in which the previous result is taken, so the store handles one word per cycle while
// the result side does not stall. The entries live in two rows of cells, one in order and one
// in reverse order, and all cells shift together, so the first entry and the last entry are
// always in the first cell of a row. The count resets to zero; cell contents need no reset.
module indexed_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  iss_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output iss_pkg::rsp_word_t rsp
);
  import iss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  status_t            status;
  status_t            status_next;
  logic               rsp_valid_next;
  logic               accept;
  cell_op_t           op;
  logic [CW-1:0]      pos_fwd;
  logic [CW-1:0]      pos_rev;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      count_ext;
  logic signed [VALUE_W-1:0] head;
  logic signed [VALUE_W-1:0] tail;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign pos_ext   = PW'(req.position);
  assign count_ext = PW'(count);

  always_comb begin
    status_next = STATUS_OK;
    op          = CELL_HOLD;
    pos_fwd     = count;
    pos_rev     = '0;
    count_next  = count;
    unique case (req.mode)
      MODE_APPEND: begin
        if (count >= CAP_COUNT) begin
          status_next = STATUS_FULL;
        end else begin
          op      = CELL_INSERT;
          pos_fwd = count;
          pos_rev = '0;
        end
      end
      MODE_INSERT: begin
        if (count >= CAP_COUNT) begin
          status_next = STATUS_FULL;
        end else if (pos_ext > count_ext) begin
          status_next = STATUS_RANGE;
        end else begin
          op      = CELL_INSERT;
          pos_fwd = CW'(pos_ext);
          pos_rev = count - CW'(pos_ext);
        end
      end
      MODE_REMOVE: begin
        if (count == '0) begin
          status_next = STATUS_UNDERFLOW;
        end else if (pos_ext >= count_ext) begin
          status_next = STATUS_RANGE;
        end else begin
          op      = CELL_REMOVE;
          pos_fwd = CW'(pos_ext);
          pos_rev = count - CW'(1) - CW'(pos_ext);
        end
      end
      default: status_next = STATUS_OK;
    endcase
    if (!accept) begin
      op = CELL_HOLD;
    end
    unique case (op)
      CELL_INSERT: count_next = count + CW'(1);
      CELL_REMOVE: count_next = count - CW'(1);
      default:     count_next = count;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (accept) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= STATUS_OK;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      if (accept) begin
        status <= status_next;
      end
    end
  end

  iss_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_forward (
    .clk   (clk),
    .op    (op),
    .pos   (pos_fwd),
    .value (req.value),
    .first (head)
  );

  iss_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_reverse (
    .clk   (clk),
    .op    (op),
    .pos   (pos_rev),
    .value (req.value),
    .first (tail)
  );

  always_comb begin
    rsp.head_value  = (count == '0) ? '0 : head;
    rsp.tail_value  = (count == '0) ? '0 : tail;
    rsp.entry_count = COUNT_W'(count);
    rsp.is_empty    = (count == '0);
    rsp.status      = status;
  end

endmodule
